>>> hdl/assert_macros.svh
// Assertion helpers shared by the transmitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check prop on every rising edge of clk, skipped while rst_n is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, also held during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> hdl/mft_pkg.sv
package mft_pkg;

	localparam int MAX_FRAME_BITS = 32;
	localparam int FRAME_CAP = (MAX_FRAME_BITS < 32) ? MAX_FRAME_BITS : 32;
	localparam int LEN_W = 6;
	localparam int TICK_W = 16;

	localparam logic [TICK_W-1:0] HBT_RESET = 16'd417;

	// Register byte offsets
	localparam logic [2:0] ADDR_HALF_BIT_TICKS = 3'd0;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_START  = 2'd1,
		PH_DATA   = 2'd2,
		PH_RETURN = 2'd3
	} tx_phase_t;

	// One result, line level in bit 0
	typedef struct packed {
		logic done_res;
		logic busy_res;
		logic line_level;
	} mft_result_t;

endpackage

>>> hdl/mft_regs.sv
module mft_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [mft_pkg::TICK_W-1:0] half_bit_ticks
);
	import mft_pkg::*;

	logic [TICK_W-1:0] hbt_q;
	logic              sel_hbt;

	// Only bit 2 selects a register; low bits are ignored.
	assign sel_hbt = (paddr[2] == ADDR_HALF_BIT_TICKS[2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hbt_q <= HBT_RESET;
		end else if (psel && penable && pwrite && pready && sel_hbt) begin
			hbt_q <= pwdata[TICK_W-1:0];
		end
	end

	assign prdata = sel_hbt ? {{(32-TICK_W){1'b0}}, hbt_q} : 32'd0;
	assign half_bit_ticks = hbt_q;

endmodule

>>> hdl/mft_core.sv
`include "assert_macros.svh"

module mft_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic                       operation,
	input  logic [31:0]                frame_value,
	input  logic [mft_pkg::LEN_W-1:0]  frame_length,
	input  logic [mft_pkg::TICK_W-1:0] half_bit_ticks,
	output mft_pkg::mft_result_t       result
);
	import mft_pkg::*;

	tx_phase_t         phase_q, phase_n;
	logic              line_q, line_n;
	logic              half_q, half_n;
	logic [TICK_W-1:0] tc_q, tc_n;
	logic [31:0]       shift_q, shift_n;
	logic [LEN_W-1:0]  rem_q, rem_n;
	logic              done_n;

	logic [LEN_W-1:0]  len_sat;
	logic [4:0]        lshift;
	logic [TICK_W-1:0] period;
	logic [TICK_W-1:0] tc_inc;
	logic [31:0]       shift_adv;
	logic [LEN_W-1:0]  rem_dec;

	assign len_sat   = (frame_length > LEN_W'(FRAME_CAP)) ? LEN_W'(FRAME_CAP) : frame_length;
	assign lshift    = 5'(LEN_W'(32) - len_sat);
	assign period    = (half_bit_ticks == '0) ? TICK_W'(1) : half_bit_ticks;
	assign tc_inc    = tc_q + TICK_W'(1);
	assign shift_adv = {shift_q[30:0], 1'b0};
	assign rem_dec   = rem_q - LEN_W'(1);

	// Next state
	always_comb begin
		phase_n = phase_q;
		line_n  = line_q;
		half_n  = half_q;
		tc_n    = tc_q;
		shift_n = shift_q;
		rem_n   = rem_q;
		done_n  = 1'b0;
		if (operation) begin
			shift_n = (len_sat == '0) ? 32'd0 : (frame_value << lshift);
			rem_n   = len_sat;
			phase_n = PH_START;
			half_n  = 1'b0;
			line_n  = 1'b0;
			tc_n    = '0;
		end else if (phase_q != PH_IDLE) begin
			if (tc_inc == '0 || tc_inc >= period) begin
				tc_n = '0;
				case (phase_q)
					PH_START: begin
						if (!half_q) begin
							half_n = 1'b1;
							line_n = 1'b1;
						end else if (rem_q == '0) begin
							phase_n = PH_IDLE;
							line_n  = 1'b1;
							half_n  = 1'b0;
							done_n  = 1'b1;
						end else begin
							phase_n = PH_DATA;
							half_n  = 1'b0;
							line_n  = ~shift_q[31];
						end
					end
					PH_DATA: begin
						if (!half_q) begin
							half_n = 1'b1;
							line_n = shift_q[31];
						end else begin
							shift_n = shift_adv;
							rem_n   = rem_dec;
							if (rem_dec == '0) begin
								half_n = 1'b0;
								line_n = 1'b1;
								if (!line_q) begin
									phase_n = PH_RETURN;
								end else begin
									phase_n = PH_IDLE;
									done_n  = 1'b1;
								end
							end else begin
								half_n = 1'b0;
								line_n = ~shift_adv[31];
							end
						end
					end
					default: begin
						// return half bit has ended
						phase_n = PH_IDLE;
						line_n  = 1'b1;
						half_n  = 1'b0;
						done_n  = 1'b1;
					end
				endcase
			end else begin
				tc_n = tc_inc;
			end
		end
	end

	// Result of the item being accepted
	always_comb begin
		result.line_level = line_n;
		result.busy_res   = (phase_n != PH_IDLE);
		result.done_res   = done_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			line_q  <= 1'b1;
			half_q  <= 1'b0;
			tc_q    <= '0;
			shift_q <= '0;
			rem_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			line_q  <= line_n;
			half_q  <= half_n;
			tc_q    <= tc_n;
			shift_q <= shift_n;
			rem_q   <= rem_n;
		end
	end

	`ASSERT_CLK(a_idle_line_high, clk, arst_n, (phase_q != PH_IDLE) || line_q, "idle line not high")
	`ASSERT_CLK(a_return_line_high, clk, arst_n, (phase_q == PH_RETURN) |-> line_q,
		"return half bit not high")
	`ASSERT_CLK(a_done_ends_frame, clk, arst_n,
		(accept && result.done_res) |=> (phase_q == PH_IDLE && tc_q == '0),
		"done without going idle")
	`ASSERT_CLK(a_rem_bound, clk, arst_n, rem_q <= LEN_W'(FRAME_CAP), "bit count out of range")

endmodule

>>> hdl/mft_outbuf.sv
`include "assert_macros.svh"

module mft_outbuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mft_pkg::mft_result_t push_data,
	output logic                 space,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mft_pkg::mft_result_t out_data
);
	import mft_pkg::*;

	mft_result_t mem_q [2];
	logic        rd_q, wr_q;
	logic [1:0]  count_q;
	logic        pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != 2'd0);
	assign space     = (count_q != 2'd2);
	assign out_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= 1'b0;
			wr_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_CLK(a_no_overflow, clk, arst_n, push |-> space, "push into full buffer")
	`ASSERT_CLK(a_count_ptrs, clk, arst_n,
		(count_q == 2'd1) == (rd_q != wr_q), "count disagrees with pointers")

endmodule

>>> hdl/manchester_frame_transmitter.sv
// Manchester frame transmitter: one biphase line level per request.
// Input stream (s_*): each request is one timer tick (s_tuser = 0) or a start
// of a new frame (s_tuser = 1) carrying frame_value and frame_length in
// s_tdata. A start loads the frame, sent MSB first, and pulls the line low
// for the start bit. Each tick advances the half-bit timer.
// Output stream (m_*): exactly one result per request: line level, busy and
// a one-request done pulse when the frame completes.
// Output: a request's result enters the two-entry result buffer when taken.
// Throughput: one request per cycle while the buffer has room, set by the
// single state update between the state registers and that buffer.
// Stall: while the receiver holds m_tready low the buffer keeps up to two
// results; s_tready drops only once both entries are full.
// Config: half_bit_ticks at byte address 0 over APB (0 acts as 1).
// Reset: line idle high, not busy, buffer empty, half_bit_ticks = 417.
module manchester_frame_transmitter (
	input  logic        clk,
	input  logic        arst_n,
	// input requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] frame_value, [37:32] frame_length, rest 0
	input  logic        s_tuser,   // [0] operation
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] line_level, [1] busy_res, [2] done_res, rest 0
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mft_pkg::*;

	logic [TICK_W-1:0] half_bit_ticks;
	logic              accept;
	logic              space;
	mft_result_t       result;
	mft_result_t       out_result;

	// Take a request whenever the result buffer has room.
	assign s_tready = space;
	assign accept   = s_tvalid && s_tready;

	mft_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.half_bit_ticks (half_bit_ticks)
	);

	// Advance the line state on every accepted request.
	mft_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.operation      (s_tuser),
		.frame_value    (s_tdata[31:0]),
		.frame_length   (s_tdata[37:32]),
		.half_bit_ticks (half_bit_ticks),
		.result         (result)
	);

	// Hold results here until the receiver takes them.
	mft_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.space     (space),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_result)
	);

	assign m_tdata = {5'd0, out_result};

endmodule
